// ===== rtl/bdeq_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bdeq_pkg
// Shared types and constants for the bounded double-ended queue.
// ---------------------------------------------------------------------------
package bdeq_pkg;

    // Ring store geometry (depth is a power of two so ring indexes wrap)
    localparam int DEPTH   = 16;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = AW + 1;
    localparam int DW      = 32;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [PADDR_W-3:0] {
        REG_CAPACITY = 1'b0
    } t_reg_idx;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_DELETE     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DEL
    } t_state;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_ram_req;

endpackage
`default_nettype wire

// ===== rtl/bounded_double_ended_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bounded_double_ended_queue
// Capacity-limited deque of signed 32-bit values held in a ring RAM.
// ---------------------------------------------------------------------------
// Results: a push, a refused action, an unused code or a delete on an empty
//   queue reports in the cycle after start, as does a pop that leaves at most
//   one entry; any other pop waits in ST_POP on the RAM read of the new end
//   entry. A delete walks the ring through the single read port in ST_DEL.
// Throughput: one push per cycle while the block is not busy; results strobe on o_done, no receiver stall.
// Synchronous reset empties the queue, sets capacity to 16, keeps RAM data.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [bdeq_pkg::PADDR_W-1:0]     paddr,
    input  wire  [bdeq_pkg::PDATA_W-1:0]     pwdata,
    output logic [bdeq_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  wire                              start,
    output logic                             busy,
    input  wire  [2:0]                       i_action,
    input  wire  signed [31:0]               i_value,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic signed [31:0]               o_popped,
    output logic signed [31:0]               o_front_value,
    output logic signed [31:0]               o_back_value,
    output logic [4:0]                       o_count,
    output logic [4:0]                       o_removed,
    output logic                             o_vacant
);

    logic [bdeq_pkg::CAP_W-1:0] capacity;
    bdeq_pkg::t_ram_req         ram_req;
    logic [bdeq_pkg::DW-1:0]    ram_rdata;

    bdeq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    bdeq_ram #(
        .DATA_W (bdeq_pkg::DW),
        .ADDR_W (bdeq_pkg::AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    bdeq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_capacity    (capacity),
        .i_rdata       (ram_rdata),
        .o_ram         (ram_req),
        .o_busy        (busy),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_popped      (o_popped),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_count       (o_count),
        .o_removed     (o_removed),
        .o_vacant      (o_vacant)
    );

endmodule
`default_nettype wire

// ===== rtl/bdeq_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bdeq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bdeq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  wire                i_clk,
    input  wire                i_we,
    input  wire [ADDR_W-1:0]   i_waddr,
    input  wire [DATA_W-1:0]   i_wdata,
    input  wire                i_re,
    input  wire [ADDR_W-1:0]   i_raddr,
    output logic [DATA_W-1:0]  o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bdeq_cfg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bdeq_cfg
// APB register file holding the capacity limit.
// ---------------------------------------------------------------------------
module bdeq_cfg (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [bdeq_pkg::PADDR_W-1:0]       paddr,
    input  wire  [bdeq_pkg::PDATA_W-1:0]       pwdata,
    output logic [bdeq_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    output logic [bdeq_pkg::CAP_W-1:0]         o_capacity
);

    logic [bdeq_pkg::CAP_W-1:0] r_capacity;
    logic                       wr_en;
    bdeq_pkg::t_reg_idx         reg_idx;

    assign reg_idx = bdeq_pkg::t_reg_idx'(paddr[bdeq_pkg::PADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bdeq_pkg::CAP_RESET;
        end else if (wr_en && (reg_idx == bdeq_pkg::REG_CAPACITY)) begin
            r_capacity <= pwdata[bdeq_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            bdeq_pkg::REG_CAPACITY:
                prdata = {{(bdeq_pkg::PDATA_W-bdeq_pkg::CAP_W){1'b0}}, r_capacity};
            default: prdata = '0;
        endcase
    end

    assign o_capacity = r_capacity;

endmodule
`default_nettype wire

// ===== rtl/bdeq_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bdeq_ctrl
// Queue sequencer: keeps head, count and cached end values, drives the ring
// RAM, and walks the store to compact it on a delete.
// ---------------------------------------------------------------------------
module bdeq_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [2:0]                       i_action,
    input  wire  [bdeq_pkg::DW-1:0]          i_value,
    input  wire  [bdeq_pkg::CAP_W-1:0]       i_capacity,
    input  wire  [bdeq_pkg::DW-1:0]          i_rdata,
    output bdeq_pkg::t_ram_req               o_ram,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [bdeq_pkg::DW-1:0]          o_popped,
    output logic [bdeq_pkg::DW-1:0]          o_front_value,
    output logic [bdeq_pkg::DW-1:0]          o_back_value,
    output logic [bdeq_pkg::CW-1:0]          o_count,
    output logic [bdeq_pkg::CW-1:0]          o_removed,
    output logic                             o_vacant
);

    localparam int AW = bdeq_pkg::AW;
    localparam int CW = bdeq_pkg::CW;
    localparam int DW = bdeq_pkg::DW;

    bdeq_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_head,    n_head;
    logic [CW-1:0]    r_count,   n_count;
    logic [DW-1:0]    r_front,   n_front;
    logic [DW-1:0]    r_back,    n_back;
    logic [DW-1:0]    r_pop_val, n_pop_val;
    logic             r_pop_head, n_pop_head;
    logic [CW-1:0]    r_rd_i,    n_rd_i;
    logic [CW-1:0]    r_kept,    n_kept;
    logic [DW-1:0]    r_del_val, n_del_val;
    logic [DW-1:0]    r_first,   n_first;
    logic [DW-1:0]    r_last,    n_last;

    logic             r_done,    n_done;
    logic [1:0]       r_status,  n_status;
    logic [DW-1:0]    r_popped,  n_popped;
    logic [DW-1:0]    r_front_o, n_front_o;
    logic [DW-1:0]    r_back_o,  n_back_o;
    logic [CW-1:0]    r_count_o, n_count_o;
    logic [CW-1:0]    r_removed, n_removed;

    logic [CW-1:0]    limit;
    logic             full;
    logic             empty;
    logic             keep;

    assign limit = (CW'(i_capacity) > CW'(bdeq_pkg::DEPTH)) ?
                   CW'(bdeq_pkg::DEPTH) : CW'(i_capacity);
    assign full  = (r_count >= limit);
    assign empty = (r_count == '0);
    assign keep  = (i_rdata != r_del_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdeq_pkg::ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front     <= n_front;
        r_back      <= n_back;
        r_pop_val   <= n_pop_val;
        r_pop_head  <= n_pop_head;
        r_rd_i      <= n_rd_i;
        r_kept      <= n_kept;
        r_del_val   <= n_del_val;
        r_first     <= n_first;
        r_last      <= n_last;
        r_status    <= n_status;
        r_popped    <= n_popped;
        r_front_o   <= n_front_o;
        r_back_o    <= n_back_o;
        r_count_o   <= n_count_o;
        r_removed   <= n_removed;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_pop_val   = r_pop_val;
        n_pop_head  = r_pop_head;
        n_rd_i      = r_rd_i;
        n_kept      = r_kept;
        n_del_val   = r_del_val;
        n_first     = r_first;
        n_last      = r_last;
        n_done      = 1'b0;
        n_status    = bdeq_pkg::STATUS_DONE;
        n_popped    = '0;
        n_removed   = '0;
        n_front_o   = r_front_o;
        n_back_o    = r_back_o;
        n_count_o   = r_count_o;
        o_ram       = '0;

        unique case (r_state)
            bdeq_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        bdeq_pkg::ACT_PUSH_FRONT: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_status = bdeq_pkg::STATUS_FULL;
                            end else begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = r_head - AW'(1);
                                o_ram.wdata = i_value;
                                n_head      = r_head - AW'(1);
                                n_count     = r_count + CW'(1);
                                n_front     = i_value;
                                if (empty) begin
                                    n_back = i_value;
                                end
                            end
                        end
                        bdeq_pkg::ACT_PUSH_BACK: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_status = bdeq_pkg::STATUS_FULL;
                            end else begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = r_head + r_count[AW-1:0];
                                o_ram.wdata = i_value;
                                n_count     = r_count + CW'(1);
                                n_back      = i_value;
                                if (empty) begin
                                    n_front = i_value;
                                end
                            end
                        end
                        bdeq_pkg::ACT_POP_FRONT: begin
                            if (empty) begin
                                n_done   = 1'b1;
                                n_status = bdeq_pkg::STATUS_EMPTY;
                            end else begin
                                n_head  = r_head + AW'(1);
                                n_count = r_count - CW'(1);
                                if (r_count > CW'(2)) begin
                                    // fetch the new front, finish next cycle
                                    o_ram.re    = 1'b1;
                                    o_ram.raddr = r_head + AW'(1);
                                    n_pop_val   = r_front;
                                    n_pop_head  = 1'b1;
                                    n_state     = bdeq_pkg::ST_POP;
                                end else begin
                                    n_done   = 1'b1;
                                    n_popped = r_front;
                                    n_front  = r_back;
                                end
                            end
                        end
                        bdeq_pkg::ACT_POP_BACK: begin
                            if (empty) begin
                                n_done   = 1'b1;
                                n_status = bdeq_pkg::STATUS_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                if (r_count > CW'(2)) begin
                                    o_ram.re    = 1'b1;
                                    o_ram.raddr = r_head + r_count[AW-1:0] - AW'(2);
                                    n_pop_val   = r_back;
                                    n_pop_head  = 1'b0;
                                    n_state     = bdeq_pkg::ST_POP;
                                end else begin
                                    n_done   = 1'b1;
                                    n_popped = r_back;
                                    n_back   = r_front;
                                end
                            end
                        end
                        bdeq_pkg::ACT_DELETE: begin
                            if (empty) begin
                                n_done = 1'b1;
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = r_head;
                                n_rd_i      = CW'(1);
                                n_kept      = '0;
                                n_del_val   = i_value;
                                n_state     = bdeq_pkg::ST_DEL;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            bdeq_pkg::ST_POP: begin
                if (r_pop_head) begin
                    n_front = i_rdata;
                end else begin
                    n_back = i_rdata;
                end
                n_done   = 1'b1;
                n_popped = r_pop_val;
                n_state  = bdeq_pkg::ST_IDLE;
            end
            bdeq_pkg::ST_DEL: begin
                // compact: survivors are written back at the kept position,
                // which never passes the read position
                if (keep) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_head + r_kept[AW-1:0];
                    o_ram.wdata = i_rdata;
                    n_kept      = r_kept + CW'(1);
                    n_last      = i_rdata;
                    if (r_kept == '0) begin
                        n_first = i_rdata;
                    end
                end
                if (r_rd_i == r_count) begin
                    n_count   = n_kept;
                    n_removed = r_count - n_kept;
                    n_front   = n_first;
                    n_back    = n_last;
                    n_done    = 1'b1;
                    n_state   = bdeq_pkg::ST_IDLE;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_head + r_rd_i[AW-1:0];
                    n_rd_i      = r_rd_i + CW'(1);
                end
            end
            default: begin
                n_state = bdeq_pkg::ST_IDLE;
            end
        endcase

        if (n_done) begin
            n_count_o = n_count;
            n_front_o = (n_count == '0) ? '0 : n_front;
            n_back_o  = (n_count == '0) ? '0 : n_back;
        end
    end

    assign o_busy        = (r_state != bdeq_pkg::ST_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_popped      = r_popped;
    assign o_front_value = r_front_o;
    assign o_back_value  = r_back_o;
    assign o_count       = r_count_o;
    assign o_removed     = r_removed;
    assign o_vacant      = (r_count_o == '0);

endmodule
`default_nettype wire

// ===== test/deque_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// deque_checker
// Watches the command, result and register ports of the bounded deque. It
// keeps a shadow deque and capacity, predicts one result per accepted
// transaction and compares each strobed result, field by field, in order.
// ---------------------------------------------------------------------------
module deque_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_psel,
    input  wire                                 i_penable,
    input  wire                                 i_pwrite,
    input  wire  [bdeq_pkg::PADDR_W-1:0]        i_paddr,
    input  wire  [bdeq_pkg::PDATA_W-1:0]        i_pwdata,
    input  wire  [bdeq_pkg::PDATA_W-1:0]        i_prdata,
    input  wire                                 i_pready,
    input  wire                                 i_start,
    input  wire                                 i_busy,
    input  wire  [2:0]                          i_action,
    input  wire  signed [bdeq_pkg::DW-1:0]      i_value,
    input  wire                                 i_done,
    input  wire  [1:0]                          i_status,
    input  wire  signed [bdeq_pkg::DW-1:0]      i_popped,
    input  wire  signed [bdeq_pkg::DW-1:0]      i_front_value,
    input  wire  signed [bdeq_pkg::DW-1:0]      i_back_value,
    input  wire  [bdeq_pkg::CW-1:0]             i_count,
    input  wire  [bdeq_pkg::CW-1:0]             i_removed,
    input  wire                                 i_vacant,
    output logic [31:0]                         o_fail_count,
    output logic [31:0]                         o_pending,
    output logic [31:0]                         o_checked,
    output logic [31:0]                         o_refusals
);

    localparam int DW = bdeq_pkg::DW;
    localparam int CW = bdeq_pkg::CW;
    localparam logic [bdeq_pkg::PADDR_W-1:0] CAPACITY_ADDR =
        {bdeq_pkg::REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic [1:0]           status;
        logic signed [DW-1:0] popped;
        logic signed [DW-1:0] front_value;
        logic signed [DW-1:0] back_value;
        logic [CW-1:0]        count;
        logic [CW-1:0]        removed;
        logic                 vacant;
    } t_deq_result;

    logic signed [DW-1:0]          shadow_deque [$];
    logic signed [DW-1:0]          survivors [$];
    logic [bdeq_pkg::CAP_W-1:0]    shadow_capacity = bdeq_pkg::CAP_RESET;
    t_deq_result                   awaited_results [$];
    int                            mismatches = 0;
    int                            checked = 0;
    int                            refusals = 0;

    initial begin
        o_fail_count = '0;
        o_pending    = '0;
        o_checked    = '0;
        o_refusals   = '0;
    end

    // Apply one action to the shadow deque and return the result it must report.
    function automatic t_deq_result apply_action(input logic [2:0] act,
                                                 input logic signed [DW-1:0] val);
        t_deq_result r;
        int          limit;
        int          i;
        r = '0;
        limit = (shadow_capacity < bdeq_pkg::DEPTH) ? int'(shadow_capacity)
                                                     : bdeq_pkg::DEPTH;
        case (act) inside
            bdeq_pkg::ACT_PUSH_FRONT, bdeq_pkg::ACT_PUSH_BACK: begin
                if (shadow_deque.size() >= limit)
                    r.status = bdeq_pkg::STATUS_FULL;
                else if (act == bdeq_pkg::ACT_PUSH_FRONT)
                    shadow_deque = {val, shadow_deque};
                else
                    shadow_deque = {shadow_deque, val};
            end
            bdeq_pkg::ACT_POP_FRONT, bdeq_pkg::ACT_POP_BACK: begin
                if (shadow_deque.size() == 0) begin
                    r.status = bdeq_pkg::STATUS_EMPTY;
                end else if (act == bdeq_pkg::ACT_POP_FRONT) begin
                    r.popped = shadow_deque[0];
                    shadow_deque.delete(0);
                end else begin
                    r.popped = shadow_deque[shadow_deque.size() - 1];
                    shadow_deque.delete(shadow_deque.size() - 1);
                end
            end
            bdeq_pkg::ACT_DELETE: begin
                // Keep non-matching entries in their original order.
                survivors.delete();
                for (i = 0; i < shadow_deque.size(); i++) begin
                    if (shadow_deque[i] != val)
                        survivors = {survivors, shadow_deque[i]};
                end
                r.removed = CW'(shadow_deque.size() - survivors.size());
                shadow_deque = survivors;
            end
            default: ;
        endcase
        r.count  = CW'(shadow_deque.size());
        r.vacant = (shadow_deque.size() == 0);
        if (shadow_deque.size() != 0) begin
            r.front_value = shadow_deque[0];
            r.back_value  = shadow_deque[shadow_deque.size() - 1];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_deq_result got;
        t_deq_result want;
        string       bad;
        if (!i_rst_n) begin
            shadow_deque.delete();
            awaited_results.delete();
            shadow_capacity = bdeq_pkg::CAP_RESET;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == CAPACITY_ADDR) begin
                if (i_pwrite)
                    shadow_capacity = i_pwdata[bdeq_pkg::CAP_W-1:0];
                else if (i_prdata[bdeq_pkg::CAP_W-1:0] !== shadow_capacity)
                    flag_mismatch($sformatf("capacity readback: expected %0d, got %0d",
                                            shadow_capacity,
                                            i_prdata[bdeq_pkg::CAP_W-1:0]));
            end

            // A result always belongs to an earlier transaction: check before queuing.
            if (i_done) begin
                got = {i_status, i_popped, i_front_value, i_back_value,
                       i_count, i_removed, i_vacant};
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result: st=%0d pop=%0d cnt=%0d",
                                            got.status, got.popped, got.count));
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    checked++;
                    bad = "";
                    if (got.status      !== want.status)      bad = {bad, " status"};
                    if (got.popped      !== want.popped)      bad = {bad, " popped"};
                    if (got.front_value !== want.front_value) bad = {bad, " front"};
                    if (got.back_value  !== want.back_value)  bad = {bad, " back"};
                    if (got.count       !== want.count)       bad = {bad, " count"};
                    if (got.removed     !== want.removed)     bad = {bad, " removed"};
                    if (got.vacant      !== want.vacant)      bad = {bad, " vacant"};
                    if (bad != "")
                        flag_mismatch($sformatf({"on%s\n  expected st=%0d pop=%0d ",
                            "front=%0d back=%0d cnt=%0d rem=%0d empty=%0d\n  got      ",
                            "st=%0d pop=%0d front=%0d back=%0d cnt=%0d rem=%0d empty=%0d"},
                            bad, want.status, want.popped, want.front_value,
                            want.back_value, want.count, want.removed, want.vacant,
                            got.status, got.popped, got.front_value, got.back_value,
                            got.count, got.removed, got.vacant));
                end
            end

            if (i_start && !i_busy) begin
                want = apply_action(i_action, i_value);
                if (want.status != bdeq_pkg::STATUS_DONE)
                    refusals++;
                awaited_results = {awaited_results, want};
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
        o_refusals   <= refusals;
    end

endmodule

// ===== test/bounded_double_ended_queue_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bounded_double_ended_queue_test
// Drives the bounded deque through directed corner cases and random
// push/pop/delete traffic under several capacity settings and sender idle
// rates; a side checker predicts and compares every result.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue_test;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 40;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int NUM_PHASES      = 10;
    localparam int PADDR_W         = bdeq_pkg::PADDR_W;
    localparam int PDATA_W         = bdeq_pkg::PDATA_W;
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR   = {bdeq_pkg::REG_CAPACITY, 2'b00};
    localparam logic [2:0]         ACT_SPARE_FIRST = 3'(bdeq_pkg::ACT_DELETE) + 3'd1;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 start    = 1'b0;
    logic                 busy;
    logic [2:0]           i_action = '0;
    logic signed [31:0]   i_value  = '0;
    logic                 o_done;
    logic [1:0]           o_status;
    logic signed [31:0]   o_popped;
    logic signed [31:0]   o_front_value;
    logic signed [31:0]   o_back_value;
    logic [4:0]           o_count;
    logic [4:0]           o_removed;
    logic                 o_vacant;

    logic [31:0]          fail_count;
    logic [31:0]          pending;
    logic [31:0]          checked;
    logic [31:0]          refusals;

    int                   items_sent = 0;
    int                   settings = 0;
    int                   idle_cycles = 0;
    int                   phase_caps [NUM_PHASES] = '{31, 16, 17, 0, 3, 15, 1, 0, 16, 8};
    int                   idle_pcts [3] = '{0, 45, 38};

    bounded_double_ended_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_popped      (o_popped),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_count       (o_count),
        .o_removed     (o_removed),
        .o_vacant      (o_vacant)
    );

    deque_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .i_start       (start),
        .i_busy        (busy),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_done        (o_done),
        .i_status      (o_status),
        .i_popped      (o_popped),
        .i_front_value (o_front_value),
        .i_back_value  (o_back_value),
        .i_count       (o_count),
        .i_removed     (o_removed),
        .i_vacant      (o_vacant),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_refusals    (refusals)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort when nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one command and hold it until the block takes it.
    task automatic send_item(input logic [2:0] act, input logic [31:0] val);
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // Randomly drop start for a few cycles, with junk on the payload.
    task automatic idle_gap(input int pct);
        int len;
        if ($urandom_range(0, 99) < pct) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
            start    <= 1'b0;
            i_action <= 3'($urandom);
            i_value  <= $urandom;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Drain: no command pending, every result back, block not busy.
    task automatic settle;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_capacity(input int cap);
        settle();
        apb_access(1'b1, PDATA_W'(cap));
        apb_access(1'b0, '0);
        settings++;
    endtask

    // Random traffic that swings between filling and draining the deque.
    task automatic run_random(input int n, input int pct);
        logic [31:0] hot [4];
        logic        filling;
        logic [2:0]  act;
        logic [31:0] val;
        int          roll;
        int          i;
        hot[0]  = $urandom;
        hot[1]  = $urandom_range(0, 3);
        hot[2]  = 32'h8000_0000;
        hot[3]  = 32'h7FFF_FFFF;
        filling = $urandom_range(0, 1);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 29) == 0)
                filling = ~filling;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                act = ACT_SPARE_FIRST + 3'($urandom_range(0, 2));
            else if (roll < 12)
                act = bdeq_pkg::ACT_DELETE;
            else if ((roll < 80) == filling)
                act = $urandom_range(0, 1) ? bdeq_pkg::ACT_PUSH_FRONT
                                           : bdeq_pkg::ACT_PUSH_BACK;
            else
                act = $urandom_range(0, 1) ? bdeq_pkg::ACT_POP_FRONT
                                           : bdeq_pkg::ACT_POP_BACK;
            // Reuse a few values so deletes find matches.
            val = ($urandom_range(0, 99) < 45) ? hot[$urandom_range(0, 3)] : $urandom;
            send_item(act, val);
            if (i != n - 1)
                idle_gap(pct);
        end
    endtask

    initial begin
        int p;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue: pops refused, delete finds nothing, spare codes do nothing.
        send_item(bdeq_pkg::ACT_POP_FRONT, 32'd0);
        send_item(bdeq_pkg::ACT_POP_BACK, 32'hFFFF_FFFF);
        send_item(bdeq_pkg::ACT_DELETE, 32'd0);
        for (k = 0; k < 3; k++)
            send_item(ACT_SPARE_FIRST + 3'(k), $urandom);
        // Extremes at both ends, then a delete that hits both ends.
        send_item(bdeq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        send_item(bdeq_pkg::ACT_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(bdeq_pkg::ACT_PUSH_FRONT, 32'd0);
        send_item(bdeq_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
        send_item(bdeq_pkg::ACT_PUSH_BACK, 32'd5);
        send_item(bdeq_pkg::ACT_PUSH_FRONT, 32'd5);
        send_item(bdeq_pkg::ACT_PUSH_BACK, 32'd5);
        send_item(ACT_SPARE_FIRST + 3'd2, 32'd5);
        send_item(bdeq_pkg::ACT_DELETE, 32'd5);
        send_item(bdeq_pkg::ACT_DELETE, 32'd12345);
        send_item(bdeq_pkg::ACT_POP_FRONT, 32'd0);
        send_item(bdeq_pkg::ACT_POP_BACK, 32'd0);
        // Two entries left: capacity at count, then below count, then zero.
        set_capacity(2);
        send_item(bdeq_pkg::ACT_PUSH_BACK, 32'hA5A5_5A5A);
        set_capacity(1);
        send_item(bdeq_pkg::ACT_PUSH_FRONT, 32'd1);
        send_item(bdeq_pkg::ACT_POP_BACK, 32'd0);
        send_item(bdeq_pkg::ACT_PUSH_BACK, 32'd2);
        send_item(bdeq_pkg::ACT_POP_FRONT, 32'd0);
        send_item(bdeq_pkg::ACT_PUSH_FRONT, 32'h1234_5678);
        set_capacity(0);
        send_item(bdeq_pkg::ACT_PUSH_BACK, 32'd3);
        send_item(bdeq_pkg::ACT_POP_BACK, 32'd0);
        send_item(bdeq_pkg::ACT_POP_FRONT, 32'd0);

        phase_caps[7] = $urandom_range(0, 31);
        for (p = 0; p < NUM_PHASES; p++) begin
            set_capacity(phase_caps[p]);
            run_random(ITEMS_PER_PHASE, idle_pcts[p % 3]);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d commands over %0d capacity settings, idle rates 0/45/38%%",
                 items_sent, settings);
        $display("compared %0d results, %0d of them full or empty refusals",
                 checked, refusals);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== bounded_double_ended_queue.f =====
rtl/bdeq_pkg.sv
rtl/bdeq_ram.sv
rtl/bdeq_cfg.sv
rtl/bdeq_ctrl.sv
rtl/bounded_double_ended_queue.sv
test/deque_checker.sv
test/bounded_double_ended_queue_test.sv
